FILE: hw/rtl/fractional_delay_string_resonator_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the string resonator
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef FRACTIONAL_DELAY_STRING_RESONATOR_ASSERT_SVH
`define FRACTIONAL_DELAY_STRING_RESONATOR_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define FDSR_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define FDSR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/fdsr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdsr_pkg
// Shared constants, types and helpers of the string resonator.
// ----------------------------------------------------------------------------
package fdsr_pkg;

  localparam int RING_DEPTH = 1024;
  localparam int RING_AW    = $clog2(RING_DEPTH);
  localparam int LEN_W      = RING_AW + 1;
  localparam int FRAC_BITS  = 16;
  localparam int SAMPLE_W   = 16;
  localparam int GAIN_W     = 16;
  localparam int DELAY_W    = 26;
  localparam int IN_W       = SAMPLE_W + GAIN_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = DELAY_W;

  // shared multiplier: signed X by unsigned Y, Y taken 4 bits per cycle
  localparam int X_W       = 34;
  localparam int Y_W       = GAIN_W;
  localparam int PROD_W    = X_W + Y_W;
  localparam int MUL_DIGIT = 4;
  localparam int MUL_STEPS = Y_W / MUL_DIGIT;
  localparam int MUL_CNT_W = $clog2(MUL_STEPS);
  localparam int S_W       = PROD_W - 15 - FRAC_BITS;

  localparam logic [GAIN_W-1:0]  ONE_Q15     = GAIN_W'(32768);
  localparam logic [GAIN_W-1:0]  DAMP_RESET  = GAIN_W'(16384);
  localparam logic [GAIN_W-1:0]  AMP_RESET   = ONE_Q15;
  localparam logic [DELAY_W-1:0] DELAY_RESET = DELAY_W'(6553600);
  localparam logic [DELAY_W-1:0] DELAY_MIN   = DELAY_W'(1) << FRAC_BITS;
  localparam logic [DELAY_W-1:0] DELAY_MAX   = DELAY_W'(RING_DEPTH - 1) << FRAC_BITS;
  localparam logic [DELAY_W-1:0] FRAC_MASK   = DELAY_W'((1 << FRAC_BITS) - 1);
  localparam logic [LEN_W-1:0]   LEN_RESET   =
    LEN_W'((DELAY_RESET + FRAC_MASK) >> FRAC_BITS) + LEN_W'(1);

  localparam logic signed [PROD_W-1:0] SAT_HI = PROD_W'(32767);
  localparam logic signed [PROD_W-1:0] SAT_LO = ~SAT_HI;

  localparam logic [CFG_IDX_W-1:0] REG_DELAY = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_DAMP  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_AMP   = CFG_IDX_W'(2);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD0,
    ST_RD1,
    ST_RD2,
    ST_RD3,
    ST_MUL_GO,
    ST_MUL_WAIT,
    ST_OUT
  } state_t;

  typedef enum logic [2:0] {
    STEP_TAP_A,
    STEP_TAP_B,
    STEP_MIX_A,
    STEP_MIX_B,
    STEP_EXC,
    STEP_ENV
  } step_t;

  typedef struct packed {
    logic               wr;
    logic               trim;
    logic [RING_AW-1:0] waddr;
    logic [RING_AW-1:0] raddr;
    logic [LEN_W-1:0]   trim_len;
  } ring_cmd_t;

  function automatic logic [GAIN_W-1:0] clamp_gain(input logic [GAIN_W-1:0] v);
    return (v > ONE_Q15) ? ONE_Q15 : v;
  endfunction

  function automatic logic [RING_AW-1:0] wrap_inc(input logic [RING_AW-1:0] idx,
                                                  input logic [LEN_W-1:0]   len);
    logic [LEN_W-1:0] nxt;
    nxt = LEN_W'(idx) + LEN_W'(1);
    return (nxt >= len) ? '0 : nxt[RING_AW-1:0];
  endfunction

endpackage

FILE: hw/rtl/fdsr_ring.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdsr_ring
// Delay ring memory, one write and one registered read per cycle. A fill
// count marks the end of the written entries and is capped at the new
// length on a length change; anything at or above it reads as zero.
// ----------------------------------------------------------------------------
module fdsr_ring
  import fdsr_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  ring_cmd_t           cmd,
  input  logic [SAMPLE_W-1:0] wdata,
  output logic [SAMPLE_W-1:0] rdata
);

  logic [SAMPLE_W-1:0] mem [RING_DEPTH];
  logic [SAMPLE_W-1:0] q_r;
  logic                hit_r;
  logic [LEN_W-1:0]    fill_r;
  logic [LEN_W-1:0]    fill_nxt;
  logic [LEN_W-1:0]    wr_end;

  assign wr_end = LEN_W'(cmd.waddr) + LEN_W'(1);

  always_comb begin
    fill_nxt = fill_r;
    priority if (cmd.trim) begin
      fill_nxt = (cmd.trim_len < fill_r) ? cmd.trim_len : fill_r;
    end else if (cmd.wr && (wr_end > fill_r)) begin
      fill_nxt = wr_end;
    end else begin
      fill_nxt = fill_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      mem[cmd.waddr] <= wdata;
    end
    q_r   <= mem[cmd.raddr];
    hit_r <= (LEN_W'(cmd.raddr) < fill_r);
  end

  assign rdata = hit_r ? q_r : '0;

endmodule

FILE: hw/rtl/fdsr_dsmul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdsr_dsmul
// Digit-serial multiplier: signed X times unsigned Y, Y shifted in
// MSB first one 4-bit digit per cycle. Done pulses after the last digit.
// ----------------------------------------------------------------------------
module fdsr_dsmul
  import fdsr_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic signed [X_W-1:0]    x,
  input  logic        [Y_W-1:0]    y,
  output logic                     busy,
  output logic                     done,
  output logic signed [PROD_W-1:0] p
);

  logic signed [X_W-1:0]         x_r;
  logic        [Y_W-1:0]         y_sh_r;
  logic signed [PROD_W-1:0]      acc_r;
  logic        [MUL_CNT_W-1:0]   cnt_r;
  logic                          busy_r;
  logic                          done_r;
  logic        [MUL_DIGIT-1:0]   digit;
  logic signed [X_W+MUL_DIGIT:0] part;

  assign digit = y_sh_r[Y_W-1 -: MUL_DIGIT];
  assign part  = x_r * $signed({1'b0, digit});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + MUL_CNT_W'(1);
      if (cnt_r == MUL_CNT_W'(MUL_STEPS - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r    <= x;
      y_sh_r <= y;
      acc_r  <= '0;
    end else if (busy_r) begin
      acc_r  <= (acc_r <<< MUL_DIGIT) + PROD_W'(part);
      y_sh_r <= y_sh_r << MUL_DIGIT;
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign p    = acc_r;

endmodule

FILE: hw/rtl/fractional_delay_string_resonator.sv
`timescale 1ns / 1ps
// One input transaction is worked at a time, and the next is accepted only in
//   idle: three ring reads through the single read port, then six products on
//   the shared 4-bit digit-serial multiplier. The result waits if the output
//   register is still held by an untaken result.
// Reset (synchronous, rst_n low): ring length 101, write index 0, fill count 0.
`include "fractional_delay_string_resonator_assert.svh"
// ----------------------------------------------------------------------------
// fractional_delay_string_resonator
// Plucked-string loop: fractional delay ring with linear interpolation,
// damping mix, excitation injection and envelope gain, saturated to 16 bits.
// ----------------------------------------------------------------------------
module fractional_delay_string_resonator
  import fdsr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // input stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_W-1:0]       in_tdata,   // [15:0] excitation, [31:16] envelope_gain
  // result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [SAMPLE_W-1:0]   out_tdata,  // [15:0] sample_out
  // configuration writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // --------------------------------------------------------------------------
  // Configuration registers. The delay is stored as its fraction plus the ring
  // length ceil(D)+1; gains are clamped to one when written.
  // --------------------------------------------------------------------------
  logic                 cfg_fire;
  logic                 cfg_delay_wr;
  logic [DELAY_W-1:0]   d_clamp;
  logic [LEN_W-1:0]     new_len;
  logic [FRAC_BITS-1:0] delay_frac_r;
  logic [LEN_W-1:0]     ring_len_r;
  logic [GAIN_W-1:0]    damp_r;
  logic [GAIN_W-1:0]    amp_r;

  assign cfg_ready    = 1'b1;
  assign cfg_fire     = cfg_valid && cfg_ready;
  assign cfg_delay_wr = cfg_fire && (cfg_index == REG_DELAY);

  always_comb begin
    priority if (cfg_data < DELAY_MIN) begin
      d_clamp = DELAY_MIN;
    end else if (cfg_data > DELAY_MAX) begin
      d_clamp = DELAY_MAX;
    end else begin
      d_clamp = cfg_data;
    end
    new_len = LEN_W'(d_clamp[DELAY_W-1:FRAC_BITS]) + LEN_W'(|d_clamp[FRAC_BITS-1:0])
            + LEN_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_frac_r <= DELAY_RESET[FRAC_BITS-1:0];
      ring_len_r   <= LEN_RESET;
      damp_r       <= DAMP_RESET;
      amp_r        <= AMP_RESET;
    end else if (cfg_fire) begin
      unique case (cfg_index)
        REG_DELAY: begin
          delay_frac_r <= d_clamp[FRAC_BITS-1:0];
          ring_len_r   <= new_len;
        end
        REG_DAMP: begin
          damp_r <= clamp_gain(cfg_data[GAIN_W-1:0]);
        end
        REG_AMP: begin
          amp_r <= clamp_gain(cfg_data[GAIN_W-1:0]);
        end
        default: begin
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  state_t state_r, state_nxt;
  step_t  step_r, step_nxt;

  logic                     in_fire;
  logic                     out_free;
  logic                     out_load;
  logic                     mul_start;
  logic                     mul_busy;
  logic                     mul_done;
  logic signed [PROD_W-1:0] mul_p;
  logic [RING_AW-1:0]       rd_addr;

  // write index and sample taps
  logic [RING_AW-1:0]        wp_r;
  logic [RING_AW-1:0]        i_r;       // tap at floor of the read position
  logic [RING_AW-1:0]        in1_c;
  logic signed [SAMPLE_W-1:0] p_r, c_r, n_r;
  logic signed [SAMPLE_W-1:0] exc_r;
  logic [GAIN_W-1:0]          env_r;
  logic signed [X_W-1:0]      ya_r, yb_r;
  logic signed [PROD_W-1:0]   acc_r;
  logic signed [SAMPLE_W-1:0] o_r;
  logic [SAMPLE_W-1:0]        ring_rdata;
  ring_cmd_t                  ring_cmd;

  logic                       out_valid_r;
  logic [SAMPLE_W-1:0]        out_data_r;

  assign in_fire  = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;
  // read position is wp - D modulo L with ceil(D) = L-1, so its integer tap is
  // wp+1 and its fraction is -D mod 1; the older tap is wp itself
  assign in1_c    = wrap_inc(i_r, ring_len_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= STEP_TAP_A;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    unique case (state_r)
      ST_IDLE: begin
        step_nxt = STEP_TAP_A;
        if (in_tvalid) begin
          state_nxt = ST_RD0;
        end
      end
      ST_RD0:    state_nxt = ST_RD1;
      ST_RD1:    state_nxt = ST_RD2;
      ST_RD2:    state_nxt = ST_RD3;
      ST_RD3:    state_nxt = ST_MUL_GO;
      ST_MUL_GO: state_nxt = ST_MUL_WAIT;
      ST_MUL_WAIT: begin
        if (mul_done) begin
          unique case (step_r)
            STEP_TAP_A: step_nxt = STEP_TAP_B;
            STEP_TAP_B: step_nxt = STEP_MIX_A;
            STEP_MIX_A: step_nxt = STEP_MIX_B;
            STEP_MIX_B: step_nxt = STEP_EXC;
            STEP_EXC:   step_nxt = STEP_ENV;
            default:    step_nxt = STEP_TAP_A;
          endcase
          state_nxt = (step_r == STEP_ENV) ? ST_OUT : ST_MUL_GO;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_tready = 1'b0;
    mul_start = 1'b0;
    out_load  = 1'b0;
    rd_addr   = wp_r;
    unique case (state_r)
      ST_IDLE:     in_tready = 1'b1;
      ST_RD0:      rd_addr   = wp_r;
      ST_RD1:      rd_addr   = i_r;
      ST_RD2:      rd_addr   = in1_c;
      ST_RD3:      ;
      ST_MUL_GO:   mul_start = 1'b1;
      ST_MUL_WAIT: ;
      ST_OUT:      out_load  = out_free;
    endcase
  end

  // --------------------------------------------------------------------------
  // Ring memory: read order is older tap, center tap, newer tap; the result is
  // written back at the write index when it moves to the output register.
  // --------------------------------------------------------------------------
  always_comb begin
    ring_cmd.wr       = out_load;
    ring_cmd.trim     = cfg_delay_wr;
    ring_cmd.waddr    = wp_r;
    ring_cmd.raddr    = rd_addr;
    ring_cmd.trim_len = new_len;
  end

  fdsr_ring u_ring (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (ring_cmd),
    .wdata (o_r),
    .rdata (ring_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
    end else if (cfg_delay_wr) begin
      wp_r <= '0;
    end else if (ring_cmd.wr) begin
      wp_r <= wrap_inc(wp_r, ring_len_r);
    end
  end

  // --------------------------------------------------------------------------
  // Multiplier operands, one product per step:
  //   TAP_A w*(n-c)  TAP_B w*(c-p)  MIX_A (1-d)*yA  MIX_B d*yB
  //   EXC a*e        ENV s*g, s = round(S / 2^31)
  // --------------------------------------------------------------------------
  logic [FRAC_BITS-1:0]        w_c;
  logic signed [SAMPLE_W:0]    diff_nc, diff_cp;
  logic signed [PROD_W-1:0]    s_rnd;
  logic signed [S_W-1:0]       s_c;
  logic signed [PROD_W-1:0]    o_rnd, o_shf;
  logic signed [SAMPLE_W-1:0]  o_sat;
  logic signed [X_W-1:0]       mul_x;
  logic [Y_W-1:0]              mul_y;

  assign w_c     = FRAC_BITS'(0) - delay_frac_r;
  assign diff_nc = {n_r[SAMPLE_W-1], n_r} - {c_r[SAMPLE_W-1], c_r};
  assign diff_cp = {c_r[SAMPLE_W-1], c_r} - {p_r[SAMPLE_W-1], p_r};
  assign s_rnd   = acc_r + (PROD_W'(1) << (14 + FRAC_BITS));
  assign s_c     = s_rnd[PROD_W-1:15+FRAC_BITS];
  assign o_rnd   = mul_p + (PROD_W'(1) << 14);
  assign o_shf   = o_rnd >>> 15;

  always_comb begin
    priority if (o_shf > SAT_HI) begin
      o_sat = SAT_HI[SAMPLE_W-1:0];
    end else if (o_shf < SAT_LO) begin
      o_sat = SAT_LO[SAMPLE_W-1:0];
    end else begin
      o_sat = o_shf[SAMPLE_W-1:0];
    end
  end

  always_comb begin
    unique case (step_r)
      STEP_TAP_A: begin
        mul_x = X_W'(diff_nc);
        mul_y = Y_W'(w_c);
      end
      STEP_TAP_B: begin
        mul_x = X_W'(diff_cp);
        mul_y = Y_W'(w_c);
      end
      STEP_MIX_A: begin
        mul_x = ya_r;
        mul_y = ONE_Q15 - damp_r;
      end
      STEP_MIX_B: begin
        mul_x = yb_r;
        mul_y = damp_r;
      end
      STEP_EXC: begin
        mul_x = X_W'(exc_r);
        mul_y = amp_r;
      end
      default: begin
        mul_x = X_W'(s_c);
        mul_y = env_r;
      end
    endcase
  end

  fdsr_dsmul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .x     (mul_x),
    .y     (mul_y),
    .busy  (mul_busy),
    .done  (mul_done),
    .p     (mul_p)
  );

  // --------------------------------------------------------------------------
  // Datapath registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (in_fire) begin
      exc_r <= in_tdata[SAMPLE_W-1:0];
      env_r <= clamp_gain(in_tdata[IN_W-1:SAMPLE_W]);
      i_r   <= wrap_inc(wp_r, ring_len_r);
    end
    if (state_r == ST_RD1) begin
      p_r <= ring_rdata;
    end
    if (state_r == ST_RD2) begin
      c_r <= ring_rdata;
    end
    if (state_r == ST_RD3) begin
      n_r <= ring_rdata;
    end
    if ((state_r == ST_MUL_WAIT) && mul_done) begin
      unique case (step_r)
        STEP_TAP_A: ya_r  <= (X_W'(c_r) <<< FRAC_BITS) + mul_p[X_W-1:0];
        STEP_TAP_B: yb_r  <= (X_W'(p_r) <<< FRAC_BITS) + mul_p[X_W-1:0];
        STEP_MIX_A: acc_r <= mul_p;
        STEP_MIX_B: acc_r <= acc_r + mul_p;
        STEP_EXC:   acc_r <= acc_r + (mul_p <<< FRAC_BITS);
        default:    o_r   <= o_sat;
      endcase
    end
  end

  // output register: frees the input side while a result waits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= o_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `FDSR_ASSERT_SAME(a_wp_in_ring, 1'b1, LEN_W'(wp_r) < ring_len_r, "write index past ring end")
  `FDSR_ASSERT_SAME(a_mul_idle_start, mul_start, !mul_busy, "multiplier started while busy")
  `FDSR_ASSERT_NEXT(a_wr_advances, ring_cmd.wr && !cfg_delay_wr, wp_r != $past(wp_r), "write index stuck")

endmodule

FILE: dv/fractional_delay_string_resonator_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fractional_delay_string_resonator_checker
// Watches the input, result and register channels of the string resonator,
// runs its own copy of the delay loop and checks each result in order.
// ----------------------------------------------------------------------------
module fractional_delay_string_resonator_checker
  import fdsr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [IN_W-1:0]       in_tdata,   // [15:0] excitation, [31:16] envelope_gain
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [SAMPLE_W-1:0]   out_tdata,  // [15:0] sample_out
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    pending
);

  logic [DELAY_W-1:0]         delay_q;
  logic [GAIN_W-1:0]          damp_q;
  logic [GAIN_W-1:0]          amp_q;
  logic signed [SAMPLE_W-1:0] ring [RING_DEPTH];
  logic [RING_AW-1:0]         wr_pos;
  logic [LEN_W-1:0]           ring_len;
  logic signed [SAMPLE_W-1:0] expected_samples [$];
  int                         errors;

  function automatic longint q15_sat(input logic [GAIN_W-1:0] v);
    return (v > ONE_Q15) ? longint'(ONE_Q15) : longint'(v);
  endfunction

  // delay clamped to [1, RING_DEPTH-1] samples
  function automatic longint loop_delay();
    if (delay_q < DELAY_MIN) return longint'(DELAY_MIN);
    if (delay_q > DELAY_MAX) return longint'(DELAY_MAX);
    return longint'(delay_q);
  endfunction

  // new delay: ring length follows, write index restarts, tail beyond it clears
  task automatic set_delay(input logic [DELAY_W-1:0] v);
    longint d;
    int     k;
    delay_q  = v;
    d        = loop_delay();
    ring_len = LEN_W'(((d + (longint'(1) << FRAC_BITS) - 1) >>> FRAC_BITS) + 1);
    wr_pos   = '0;
    for (k = int'(ring_len); k < RING_DEPTH; k++) ring[k] = '0;
  endtask

  function automatic logic signed [SAMPLE_W-1:0] ring_next_sample(
    input logic [IN_W-1:0] item
  );
    longint one_f, pos, w, c, p, n, ya, yb, acc, s, g, a, d, e, o;
    int     len, wp, i, ip, inx;
    one_f = longint'(1) << FRAC_BITS;
    len   = int'(ring_len);
    wp    = int'(wr_pos);
    pos   = longint'(wp) * one_f - loop_delay();
    if (pos < 0) pos += longint'(len) * one_f;
    i   = int'(pos >>> FRAC_BITS);
    w   = pos & (one_f - 1);
    ip  = (i == 0) ? len - 1 : i - 1;
    inx = (i + 1 >= len) ? 0 : i + 1;
    c   = ring[i];
    p   = ring[ip];
    n   = ring[inx];
    // two interpolated taps one sample apart
    ya  = c * one_f + w * (n - c);
    yb  = p * one_f + w * (c - p);
    e   = $signed(item[SAMPLE_W-1:0]);
    g   = q15_sat(item[IN_W-1:SAMPLE_W]);
    a   = q15_sat(amp_q);
    d   = q15_sat(damp_q);
    acc = a * e * one_f + (longint'(ONE_Q15) - d) * ya + d * yb;
    s   = (acc + (longint'(1) << (14 + FRAC_BITS))) >>> (15 + FRAC_BITS);
    o   = (s * g + 16384) >>> 15;
    if (o > 32767) o = 32767;
    if (o < -32768) o = -32768;
    ring[wp] = o[SAMPLE_W-1:0];
    wr_pos   = (wp + 1 >= len) ? '0 : RING_AW'(wp + 1);
    return o[SAMPLE_W-1:0];
  endfunction

  always @(posedge clk) begin
    logic signed [SAMPLE_W-1:0] exp_sample;
    if (!rst_n) begin
      foreach (ring[k]) ring[k] = '0;
      damp_q = DAMP_RESET;
      amp_q  = AMP_RESET;
      set_delay(DELAY_RESET);
      expected_samples.delete();
      errors = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_DELAY: set_delay(cfg_data);
          REG_DAMP:  damp_q = cfg_data[GAIN_W-1:0];
          REG_AMP:   amp_q  = cfg_data[GAIN_W-1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) expected_samples.push_back(ring_next_sample(in_tdata));
      if (out_tvalid && out_tready) begin
        if (expected_samples.size() == 0) begin
          if (errors < 10)
            $display("%0t: unexpected result sample_out %0d", $realtime, $signed(out_tdata));
          errors++;
        end else begin
          exp_sample = expected_samples.pop_front();
          if (out_tdata !== exp_sample) begin
            if (errors < 10)
              $display("%0t: sample_out expected %0d got %0d", $realtime, exp_sample,
                       $signed(out_tdata));
            errors++;
          end
        end
      end
    end
    fail_count <= errors;
    pending    <= expected_samples.size();
  end

endmodule

FILE: dv/fractional_delay_string_resonator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fractional_delay_string_resonator_tb
// Drives plucked-string stimulus through the resonator over a series of loop
// delay, damping and amplitude settings, with random gaps on both streams and
// one long output stall; the checker beside the block predicts every sample.
// ----------------------------------------------------------------------------
module fractional_delay_string_resonator_tb;
  import fdsr_pkg::*;

  // index with no register behind it, the block must drop such writes
  localparam logic [CFG_IDX_W-1:0] REG_NONE = CFG_IDX_W'(3);
  localparam int PHASES      = 14;
  localparam int PHASE_ITEMS = 140;
  localparam int HOLD_CYCLES = 600;   // long output stall, fills the block

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_W-1:0]       in_tdata   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [SAMPLE_W-1:0]   out_tdata;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;

  int fail_count;
  int pending;

  // idling switches, changed per phase by the stimulus process
  bit tx_idle_en   = 1'b0;
  bit rx_idle_en   = 1'b0;
  bit hold_off_req = 1'b0;
  bit hold_done    = 1'b0;
  int burst_left   = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  fractional_delay_string_resonator u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  fractional_delay_string_resonator_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // one input transaction; valid stays up unless a gap follows
  task automatic send_item(input logic [SAMPLE_W-1:0] exc, input logic [GAIN_W-1:0] gain);
    in_tvalid <= 1'b1;
    in_tdata  <= {gain, exc};
    do @(posedge clk); while (!in_tready);
    if (tx_idle_en && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  // caller lowers cfg_valid after the last write of a group
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // first edge lets the checker see the last accepted item
  task automatic wait_drained();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // register writes only with the block idle; upper data bits of the gain
  // registers carry random junk that must be dropped
  task automatic program_voice(input bit set_dly, input logic [DELAY_W-1:0] dly,
                               input logic [GAIN_W-1:0] damp,
                               input logic [GAIN_W-1:0] amp, input bit stray);
    in_tvalid <= 1'b0;
    wait_drained();
    if (set_dly) write_reg(REG_DELAY, dly);
    write_reg(REG_DAMP, {10'($urandom), damp});
    write_reg(REG_AMP, {10'($urandom), amp});
    if (stray) write_reg(REG_NONE, CFG_DATA_W'($urandom));
    cfg_valid <= 1'b0;
  endtask

  // damping / amplitude values, extremes and above-one values included
  function automatic logic [GAIN_W-1:0] pick_gain();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return ONE_Q15;
      2:       return GAIN_W'($urandom);
      default: return GAIN_W'($urandom_range(0, 32768));
    endcase
  endfunction

  // pluck-shaped traffic: noise bursts, then mostly silence while the loop
  // rings; envelope near one with the odd fully random or over-range value
  task automatic pluck_item();
    logic [SAMPLE_W-1:0] exc;
    logic [GAIN_W-1:0]   gain;
    if (burst_left == 0 && $urandom_range(0, 49) == 0) burst_left = $urandom_range(2, 40);
    if (burst_left > 0) begin
      exc = SAMPLE_W'($urandom);
      burst_left--;
    end else begin
      exc = ($urandom_range(0, 15) == 0) ? SAMPLE_W'($urandom) : '0;
    end
    case ($urandom_range(0, 9))
      0:       gain = GAIN_W'($urandom);
      1:       gain = ONE_Q15;
      default: gain = GAIN_W'($urandom_range(24000, 32768));
    endcase
    send_item(exc, gain);
  endtask

  // receiver: ready by default, random stalls, one long hold-off on request
  initial begin
    forever begin
      if (hold_off_req && !hold_done) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin
    int                 ph;
    int                 k;
    logic [DELAY_W-1:0] dly;
    bit                 set_dly;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: 100-sample delay, ring still silent
    send_item(16'sh7fff, ONE_Q15);
    send_item(16'sh8000, ONE_Q15);
    send_item(16'sh7fff, 16'hffff);   // envelope above one
    send_item(16'sh8000, 16'h0000);
    send_item(16'h1234, 16'h0001);

    // delay below one sample, both gains above one, stray register index
    program_voice(1'b1, '0, 16'hffff, 16'hffff, 1'b1);
    send_item(16'sh7fff, ONE_Q15);
    send_item(16'h0000, ONE_Q15);
    send_item(16'h0000, ONE_Q15);
    send_item(16'sh8000, 16'h8001);
    send_item(16'h5555, 16'haaaa);
    send_item(16'haaaa, 16'h5555);

    // one and a half samples, pure newer tap
    program_voice(1'b1, DELAY_W'(32'h18000), 16'h0000, ONE_Q15, 1'b0);
    send_item(16'sh4000, ONE_Q15);
    for (k = 0; k < 4; k++) send_item(16'h0000, ONE_Q15);

    // delay far above the ring, no excitation, pure older tap
    program_voice(1'b1, DELAY_W'(32'h3ffffff), ONE_Q15, 16'h0000, 1'b0);
    for (k = 0; k < 3; k++) send_item(16'sh7fff, ONE_Q15);

    // gain registers only: write index and ring keep running
    program_voice(1'b0, '0, 16'd20000, 16'd16384, 1'b0);
    for (k = 0; k < 3; k++) send_item(16'sh2000, 16'd30000);

    // random phases, each with its own setting
    for (ph = 0; ph < PHASES; ph++) begin
      case ($urandom_range(0, 9))
        0:       dly = DELAY_W'($urandom);
        1:       dly = DELAY_W'($urandom_range(0, 65535));
        2:       dly = DELAY_MAX;
        3:       dly = DELAY_MAX + DELAY_W'($urandom_range(1, 4000));
        default: dly = DELAY_W'($urandom_range(65536, 48 << 16));
      endcase
      set_dly = (ph == 0) || ($urandom_range(0, 3) != 0);
      program_voice(set_dly, dly, pick_gain(), pick_gain(), $urandom_range(0, 3) == 0);

      // no idling at all toward the end of the run
      tx_idle_en = (ph < PHASES - 2) && ($urandom_range(0, 3) != 0);
      rx_idle_en = (ph < PHASES - 2) && ($urandom_range(0, 3) != 0);
      // back-pressure phase: sender keeps offering while the receiver holds
      if (ph == 3) begin
        tx_idle_en   = 1'b0;
        hold_off_req = 1'b1;
      end
      burst_left = $urandom_range(4, 40);
      for (k = 0; k < PHASE_ITEMS; k++) pluck_item();
    end

    in_tvalid <= 1'b0;
    wait_drained();
    repeat (60) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("fractional_delay_string_resonator_tb: PASS");
    end else begin
      $display("fractional_delay_string_resonator_tb: FAIL");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #3000000;
    $display("fractional_delay_string_resonator_tb: FAIL");
    $finish;
  end

endmodule
